[rtl/servo_status_packet_parser_unit_assert.svh]
// Assertion macros for the servo status packet parser.
// Used by servo_status_packet_parser_unit; depends on nothing else.
`ifndef SERVO_STATUS_PACKET_PARSER_UNIT_ASSERT_SVH
`define SERVO_STATUS_PACKET_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSPP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SSPP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sspp_pkg.sv]
// Shared types and codes for the servo status packet parser.
// No dependencies.
package sspp_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
    localparam logic [7:0]  HEADER_EXTRA  = 8'd2;

    localparam logic [7:0]  RST_EXPECTED_ID   = 8'd1;
    localparam logic [7:0]  RST_PARAM_CAP     = 8'd4;
    localparam logic [7:0]  RST_ALLOWED_MASK  = 8'd0;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd120;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_ARM  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_EXPECTED_ID  = 2'd0,
        CFG_PARAM_CAP    = 2'd1,
        CFG_ALLOWED_MASK = 2'd2,
        CFG_TIMEOUT      = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OUT_OK       = 3'd0,
        OUT_TIMEOUT  = 3'd1,
        OUT_PROTO    = 3'd2,
        OUT_CHECKSUM = 3'd3,
        OUT_STATUS   = 3'd4
    } outcome_t;

    typedef enum logic {
        KIND_PARAM  = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_HUNT  = 7'b0000010,
        PH_ID    = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_ERR   = 7'b0010000,
        PH_PARAM = 7'b0100000,
        PH_SUM   = 7'b1000000
    } phase_t;

endpackage

[rtl/servo_status_packet_parser_unit.sv]
// Servo status reply parser: input word register, one-step state update, result register.
// Depends on sspp_pkg and servo_status_packet_parser_unit_assert.svh.
// An accepted word passes the input register and then the result register before any result it yields is valid.
// Throughput: one word per cycle while m_tready is high; the state update is single-pass.
// Reset (aresetn low, synchronous): control and config registers back to defaults, parser idle, no result held.
// Words other than arm are dropped while idle.
`include "servo_status_packet_parser_unit_assert.svh"

module servo_status_packet_parser_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sspp_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [sspp_pkg::CFG_DAT_W-1:0]     cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sspp_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] rx_byte
    input  logic [sspp_pkg::S_TUSER_W-1:0]     s_tuser,  // [1:0] cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] param_byte, [15:8] param_index, [18:16] outcome, [26:19] status,
    // [34:27] param_total, [39:35] zero
    output logic [sspp_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [sspp_pkg::M_TUSER_W-1:0]     m_tuser   // [0] kind
);

    logic [7:0]  expected_id_reg;
    logic [7:0]  param_cap_reg;
    logic [7:0]  allowed_mask_reg;
    logic [15:0] timeout_ticks_reg;

    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_byte_reg;

    sspp_pkg::phase_t phase_reg, phase_next;
    logic        last_sync_reg, last_sync_next;
    logic [7:0]  reply_id_reg, reply_id_next;
    logic [7:0]  reply_len_reg, reply_len_next;
    logic [7:0]  reply_status_reg, reply_status_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  byte_idx_reg, byte_idx_next;
    logic [15:0] elapsed_reg, elapsed_next;

    logic                 res_valid;
    sspp_pkg::kind_t      res_kind;
    logic [7:0]           res_byte;
    logic [7:0]           res_index;
    sspp_pkg::outcome_t   res_outcome;
    logic [7:0]           res_status;
    logic [7:0]           res_count;

    logic                 m_valid_reg;
    sspp_pkg::kind_t      m_kind_reg;
    logic [7:0]           m_byte_reg;
    logic [7:0]           m_index_reg;
    sspp_pkg::outcome_t   m_outcome_reg;
    logic [7:0]           m_status_reg;
    logic [7:0]           m_count_reg;

    logic        fire;
    logic [7:0]  param_num;
    logic [7:0]  byte_idx_inc;

    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign param_num    = reply_len_reg - sspp_pkg::HEADER_EXTRA;
    assign byte_idx_inc = byte_idx_reg + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg   <= sspp_pkg::RST_EXPECTED_ID;
            param_cap_reg     <= sspp_pkg::RST_PARAM_CAP;
            allowed_mask_reg  <= sspp_pkg::RST_ALLOWED_MASK;
            timeout_ticks_reg <= sspp_pkg::RST_TIMEOUT_TICKS;
        end else if (cfg_wr_en) begin
            unique case (sspp_pkg::cfg_idx_t'(cfg_wr_index))
                sspp_pkg::CFG_EXPECTED_ID:  expected_id_reg   <= cfg_wr_data[7:0];
                sspp_pkg::CFG_PARAM_CAP:    param_cap_reg     <= cfg_wr_data[7:0];
                sspp_pkg::CFG_ALLOWED_MASK: allowed_mask_reg  <= cfg_wr_data[7:0];
                sspp_pkg::CFG_TIMEOUT:      timeout_ticks_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        last_sync_next    = last_sync_reg;
        reply_id_next     = reply_id_reg;
        reply_len_next    = reply_len_reg;
        reply_status_next = reply_status_reg;
        sum_next          = sum_reg;
        byte_idx_next     = byte_idx_reg;
        elapsed_next      = elapsed_reg;
        res_valid         = 1'b0;
        res_kind          = sspp_pkg::KIND_REPORT;
        res_byte          = 8'd0;
        res_index         = 8'd0;
        res_outcome       = sspp_pkg::OUT_OK;
        res_status        = reply_status_reg;
        res_count         = 8'd0;

        if (sspp_pkg::cmd_t'(in_cmd_reg) == sspp_pkg::CMD_ARM) begin
            phase_next        = sspp_pkg::PH_HUNT;
            last_sync_next    = 1'b0;
            reply_id_next     = 8'd0;
            reply_len_next    = 8'd0;
            reply_status_next = 8'd0;
            sum_next          = 8'd0;
            byte_idx_next     = 8'd0;
            elapsed_next      = 16'd0;
        end else if (sspp_pkg::cmd_t'(in_cmd_reg) == sspp_pkg::CMD_TICK &&
                     phase_reg != sspp_pkg::PH_IDLE) begin
            if (elapsed_reg != 16'hFFFF) begin
                elapsed_next = elapsed_reg + 16'd1;
            end
            if (elapsed_next >= timeout_ticks_reg) begin
                res_valid   = 1'b1;
                res_outcome = sspp_pkg::OUT_TIMEOUT;
                phase_next  = sspp_pkg::PH_IDLE;
            end
        end else if (sspp_pkg::cmd_t'(in_cmd_reg) == sspp_pkg::CMD_BYTE) begin
            unique case (phase_reg)
                sspp_pkg::PH_IDLE: ;
                sspp_pkg::PH_HUNT: begin
                    if (last_sync_reg && in_byte_reg == sspp_pkg::SYNC_BYTE) begin
                        phase_next = sspp_pkg::PH_ID;
                    end
                    last_sync_next = (in_byte_reg == sspp_pkg::SYNC_BYTE);
                end
                sspp_pkg::PH_ID: begin
                    reply_id_next = in_byte_reg;
                    phase_next    = sspp_pkg::PH_LEN;
                end
                sspp_pkg::PH_LEN: begin
                    reply_len_next = in_byte_reg;
                    phase_next     = sspp_pkg::PH_ERR;
                end
                sspp_pkg::PH_ERR: begin
                    reply_status_next = in_byte_reg;
                    if (reply_id_reg != expected_id_reg ||
                        reply_len_reg < sspp_pkg::HEADER_EXTRA ||
                        param_num > param_cap_reg) begin
                        res_valid   = 1'b1;
                        res_outcome = sspp_pkg::OUT_PROTO;
                        res_status  = in_byte_reg;
                        phase_next  = sspp_pkg::PH_IDLE;
                    end else begin
                        sum_next      = reply_id_reg + reply_len_reg + in_byte_reg;
                        byte_idx_next = 8'd0;
                        phase_next    = (reply_len_reg == sspp_pkg::HEADER_EXTRA) ?
                                        sspp_pkg::PH_SUM : sspp_pkg::PH_PARAM;
                    end
                end
                sspp_pkg::PH_PARAM: begin
                    res_valid     = 1'b1;
                    res_kind      = sspp_pkg::KIND_PARAM;
                    res_byte      = in_byte_reg;
                    res_index     = byte_idx_reg;
                    res_status    = 8'd0;
                    sum_next      = sum_reg + in_byte_reg;
                    byte_idx_next = byte_idx_inc;
                    if (byte_idx_inc >= param_num) begin
                        phase_next = sspp_pkg::PH_SUM;
                    end
                end
                sspp_pkg::PH_SUM: begin
                    res_valid  = 1'b1;
                    phase_next = sspp_pkg::PH_IDLE;
                    if (in_byte_reg != ~sum_reg) begin
                        res_outcome = sspp_pkg::OUT_CHECKSUM;
                    end else if ((reply_status_reg & ~allowed_mask_reg) != 8'd0) begin
                        res_outcome = sspp_pkg::OUT_STATUS;
                    end else begin
                        res_outcome = sspp_pkg::OUT_OK;
                        res_count   = param_num;
                    end
                end
                default: phase_next = sspp_pkg::PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= sspp_pkg::PH_IDLE;
            last_sync_reg    <= 1'b0;
            reply_id_reg     <= 8'd0;
            reply_len_reg    <= 8'd0;
            reply_status_reg <= 8'd0;
            sum_reg          <= 8'd0;
            byte_idx_reg     <= 8'd0;
            elapsed_reg      <= 16'd0;
        end else if (fire) begin
            phase_reg        <= phase_next;
            last_sync_reg    <= last_sync_next;
            reply_id_reg     <= reply_id_next;
            reply_len_reg    <= reply_len_next;
            reply_status_reg <= reply_status_next;
            sum_reg          <= sum_next;
            byte_idx_reg     <= byte_idx_next;
            elapsed_reg      <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (fire && res_valid) begin
            m_kind_reg    <= res_kind;
            m_byte_reg    <= res_byte;
            m_index_reg   <= res_index;
            m_outcome_reg <= res_outcome;
            m_status_reg  <= res_status;
            m_count_reg   <= res_count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_status_reg, m_outcome_reg, m_index_reg, m_byte_reg};

    `SSPP_ASSERT_NEXT(a_arm_starts_hunt, aclk, aresetn,
        fire && sspp_pkg::cmd_t'(in_cmd_reg) == sspp_pkg::CMD_ARM,
        phase_reg == sspp_pkg::PH_HUNT && elapsed_reg == 16'd0, "arm did not start hunt")
    `SSPP_ASSERT_NEXT(a_report_goes_idle, aclk, aresetn,
        fire && res_valid && res_kind == sspp_pkg::KIND_REPORT,
        phase_reg == sspp_pkg::PH_IDLE && m_valid_reg, "report did not end receive")
    `SSPP_ASSERT_NOW(a_no_overwrite, aclk, aresetn,
        fire && res_valid, !m_valid_reg || m_tready, "result register overwritten")

endmodule
